@@ design/spht_pkg.sv @@
// Shared types, constants and helper functions of the shape proximity hit test.
package spht_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int RAD_W      = 15;
    localparam int R2_W       = 2 * RAD_W;
    localparam int MUL_B_W    = DIFF_W + 1;
    localparam int PROD_W     = DIFF_W + MUL_B_W;
    localparam int ACC_W      = 55;
    localparam int C1_W       = 36;
    localparam int QUO_W      = DIFF_W;
    localparam int DVS_W      = C1_W;
    localparam int DVD_W      = DVS_W + QUO_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int STATE_W    = 5;
    localparam int OP_W       = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd2;

    localparam logic [1:0] KIND_POINT = 2'd0;

    localparam logic signed [COORD_W-1:0] SENT_HI = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] SENT_LO = 16'sh8000;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NOP      = 5'd0;
    localparam op_t OP_LOAD     = 5'd1;
    localparam op_t OP_FIRST    = 5'd2;
    localparam op_t OP_PREV     = 5'd3;
    localparam op_t OP_SEG_PREV = 5'd4;
    localparam op_t OP_SEG_FRST = 5'd5;
    localparam op_t OP_BOX      = 5'd6;
    localparam op_t OP_VW       = 5'd7;
    localparam op_t OP_C1A      = 5'd8;
    localparam op_t OP_C1B      = 5'd9;
    localparam op_t OP_C2A      = 5'd10;
    localparam op_t OP_C2B      = 5'd11;
    localparam op_t OP_TGT_A    = 5'd12;
    localparam op_t OP_TGT_B    = 5'd13;
    localparam op_t OP_PXA      = 5'd14;
    localparam op_t OP_PXB      = 5'd15;
    localparam op_t OP_PYA      = 5'd16;
    localparam op_t OP_PYB      = 5'd17;
    localparam op_t OP_DIV_X    = 5'd18;
    localparam op_t OP_DIV_Y    = 5'd19;
    localparam op_t OP_LX       = 5'd20;
    localparam op_t OP_LY       = 5'd21;
    localparam op_t OP_NP_SET   = 5'd22;
    localparam op_t OP_NP_DX    = 5'd23;
    localparam op_t OP_NP_DY    = 5'd24;
    localparam op_t OP_NP_CMP   = 5'd25;
    localparam op_t OP_CR_SET_N = 5'd26;
    localparam op_t OP_CR_SET_C = 5'd27;
    localparam op_t OP_CR_MUL   = 5'd28;
    localparam op_t OP_CR_DIV   = 5'd29;
    localparam op_t OP_CR_CMP   = 5'd30;
    localparam op_t OP_RESULT   = 5'd31;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic [1:0]                shape_kind;
        logic                      last_vertex;
    } in_item_t;

    typedef struct packed {
        logic hit;
        logic inside_res;
        logic near_edge;
    } out_item_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic       box_ok;
        logic       c1_pos;
        logic       c2_le_c1;
        logic       cross_cond;
        logic       div_busy;
        logic [1:0] kind;
        logic       last;
    } stat_t;

    function automatic logic is_sent(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
        return (x == SENT_HI) || (x == SENT_LO) || (y == SENT_HI) || (y == SENT_LO);
    endfunction

    function automatic logic signed [DIFF_W-1:0] sub_c(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

endpackage

@@ design/spht_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module spht_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [spht_pkg::DVD_W-1:0]  dividend,
    input  logic [spht_pkg::DVS_W-1:0]  divisor,
    output logic                        busy,
    output logic [spht_pkg::QUO_W-1:0]  quotient
);
    import spht_pkg::*;

    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     sh_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]       trial, diff;
    logic                 ge;

    always_comb begin
        trial    = {rem_reg, sh_reg[QUO_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(QUO_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DVD_W-1:QUO_W];
            sh_reg  <= dividend[QUO_W-1:0];
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[QUO_W-2:0], ge};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = sh_reg;

endmodule

@@ design/spht_dp.sv @@
// Datapath: vertex and segment registers, shared multiply-accumulate, divider and flags.
module spht_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [spht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spht_pkg::COORD_W-1:0]    cfg_data,
    input  spht_pkg::in_item_t              in_item,
    input  spht_pkg::cmd_t                  cmd,
    output spht_pkg::stat_t                 stat,
    output spht_pkg::out_item_t             out_item
);
    import spht_pkg::*;

    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [R2_W-1:0]           r2_reg;
    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg, first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, tx_reg, ty_reg, ix_reg;
    logic [1:0]                kind_reg;
    logic                      last_reg;
    logic signed [DIFF_W-1:0]  vx_reg, vy_reg, wx_reg, wy_reg, dx_reg, dy_reg;
    logic signed [DIFF_W-1:0]  e1_reg, e2_reg, e3_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [C1_W-1:0]    c1_reg;
    logic [C1_W-1:0]           c2_reg;
    logic                      sent_reg, box_ok_reg, ccond_reg, qneg_reg;
    logic                      parity_reg, near_reg;
    out_item_t                 out_reg;

    logic [DIFF_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      mul_neg, mul_sh, mul_acc;
    logic [PROD_W-1:0]         prod;
    logic signed [ACC_W-1:0]   term_mag, term, mac, acc_abs, c1_ext, r2_ext;

    logic signed [COORD_W+1:0] d18, qx18, qy18, lox, hix, loy, hiy;
    logic signed [COORD_W-1:0] mnx, mxx, mny, mxy;
    logic                      box_ok_next;

    logic                      div_start, div_busy;
    logic [DVD_W-1:0]          div_dvd;
    logic [DVS_W-1:0]          div_dvs;
    logic [QUO_W-1:0]          quo;
    logic signed [QUO_W:0]     sq_mag, sq;
    logic signed [QUO_W:0]     lx_sum, ly_sum;
    logic signed [QUO_W+1:0]   cx_sum, qx19;
    logic                      cross_hit, in_poly;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_sh  = 1'b0;
        mul_acc = 1'b0;
        case (cmd.op)
            OP_C1A: begin
                mul_a = abs_d(vx_reg); mul_b = {1'b0, abs_d(wx_reg)};
                mul_neg = vx_reg[DIFF_W-1] ^ wx_reg[DIFF_W-1];
            end
            OP_C1B: begin
                mul_a = abs_d(vy_reg); mul_b = {1'b0, abs_d(wy_reg)};
                mul_neg = vy_reg[DIFF_W-1] ^ wy_reg[DIFF_W-1]; mul_acc = 1'b1;
            end
            OP_C2A: begin
                mul_a = abs_d(vx_reg); mul_b = {1'b0, abs_d(vx_reg)};
            end
            OP_C2B: begin
                mul_a = abs_d(vy_reg); mul_b = {1'b0, abs_d(vy_reg)}; mul_acc = 1'b1;
            end
            OP_PXA: begin
                mul_a = abs_d(vx_reg); mul_b = c1_reg[MUL_B_W-1:0];
            end
            OP_PXB: begin
                mul_a = abs_d(vx_reg); mul_b = c1_reg[C1_W-1:MUL_B_W];
                mul_sh = 1'b1; mul_acc = 1'b1;
            end
            OP_PYA: begin
                mul_a = abs_d(vy_reg); mul_b = c1_reg[MUL_B_W-1:0];
            end
            OP_PYB: begin
                mul_a = abs_d(vy_reg); mul_b = c1_reg[C1_W-1:MUL_B_W];
                mul_sh = 1'b1; mul_acc = 1'b1;
            end
            OP_NP_DX: begin
                mul_a = abs_d(dx_reg); mul_b = {1'b0, abs_d(dx_reg)};
            end
            OP_NP_DY: begin
                mul_a = abs_d(dy_reg); mul_b = {1'b0, abs_d(dy_reg)}; mul_acc = 1'b1;
            end
            OP_CR_MUL: begin
                mul_a = abs_d(e1_reg); mul_b = {1'b0, abs_d(e2_reg)};
                mul_neg = e1_reg[DIFF_W-1] ^ e2_reg[DIFF_W-1];
            end
            default: begin
                mul_a = '0;
            end
        endcase
        prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
        term_mag = {{(ACC_W-PROD_W){1'b0}}, prod};
        if (mul_sh) begin
            term_mag = term_mag <<< MUL_B_W;
        end
        term = mul_neg ? -term_mag : term_mag;
        mac  = (mul_acc ? acc_reg : '0) + term;
    end

    always_comb begin
        d18  = {3'b000, rad_reg};
        qx18 = {{2{qx_reg[COORD_W-1]}}, qx_reg};
        qy18 = {{2{qy_reg[COORD_W-1]}}, qy_reg};
        mnx  = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        mxx  = (ax_reg < bx_reg) ? bx_reg : ax_reg;
        mny  = (ay_reg < by_reg) ? ay_reg : by_reg;
        mxy  = (ay_reg < by_reg) ? by_reg : ay_reg;
        lox  = {{2{mnx[COORD_W-1]}}, mnx} - d18;
        hix  = {{2{mxx[COORD_W-1]}}, mxx} + d18;
        loy  = {{2{mny[COORD_W-1]}}, mny} - d18;
        hiy  = {{2{mxy[COORD_W-1]}}, mxy} + d18;
        box_ok_next = !((qx18 < lox) || (qx18 > hix) || (qy18 < loy) || (qy18 > hiy));
    end

    always_comb begin
        acc_abs   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        c1_ext    = {{(ACC_W-C1_W){c1_reg[C1_W-1]}}, c1_reg};
        r2_ext    = {{(ACC_W-R2_W){1'b0}}, r2_reg};
        div_start = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y) || (cmd.op == OP_CR_DIV);
        if (cmd.op == OP_CR_DIV) begin
            div_dvd = acc_abs[DVD_W-1:0];
            div_dvs = {{(DVS_W-DIFF_W){1'b0}}, abs_d(e3_reg)};
        end else begin
            div_dvd = acc_reg[DVD_W-1:0];
            div_dvs = c2_reg;
        end
        sq_mag    = {1'b0, quo};
        sq        = qneg_reg ? -sq_mag : sq_mag;
        lx_sum    = {{2{ax_reg[COORD_W-1]}}, ax_reg} + sq;
        ly_sum    = {{2{ay_reg[COORD_W-1]}}, ay_reg} + sq;
        cx_sum    = {{3{ix_reg[COORD_W-1]}}, ix_reg} + {sq[QUO_W], sq};
        qx19      = {{3{qx_reg[COORD_W-1]}}, qx_reg};
        cross_hit = qx19 < cx_sum;
        in_poly   = kind_reg[1] && parity_reg;
    end

    spht_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg      <= '0;
            qy_reg      <= '0;
            rad_reg     <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            parity_reg  <= 1'b0;
            near_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_QUERY_X: qx_reg  <= cfg_data;
                    CFG_QUERY_Y: qy_reg  <= cfg_data;
                    CFG_RADIUS:  rad_reg <= cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_FIRST: begin
                    first_x_reg <= cur_x_reg;
                    first_y_reg <= cur_y_reg;
                    parity_reg  <= 1'b0;
                    near_reg    <= 1'b0;
                end
                OP_PREV: begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                end
                OP_NP_CMP: begin
                    if (!sent_reg && (acc_reg <= r2_ext)) begin
                        near_reg <= 1'b1;
                    end
                end
                OP_CR_CMP: begin
                    if (cross_hit) begin
                        parity_reg <= ~parity_reg;
                    end
                end
                OP_RESULT: begin
                    parity_reg <= 1'b0;
                    near_reg   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= R2_W'(rad_reg) * R2_W'(rad_reg);
        case (cmd.op)
            OP_LOAD: begin
                cur_x_reg <= in_item.vert_x;
                cur_y_reg <= in_item.vert_y;
                kind_reg  <= in_item.shape_kind;
                last_reg  <= in_item.last_vertex;
            end
            OP_FIRST: begin
                tx_reg <= cur_x_reg;
                ty_reg <= cur_y_reg;
            end
            OP_SEG_PREV: begin
                ax_reg <= prev_x_reg; ay_reg <= prev_y_reg;
                bx_reg <= cur_x_reg;  by_reg <= cur_y_reg;
            end
            OP_SEG_FRST: begin
                ax_reg <= first_x_reg; ay_reg <= first_y_reg;
                bx_reg <= cur_x_reg;   by_reg <= cur_y_reg;
            end
            OP_BOX: box_ok_reg <= box_ok_next;
            OP_VW: begin
                vx_reg <= sub_c(bx_reg, ax_reg);
                vy_reg <= sub_c(by_reg, ay_reg);
                wx_reg <= sub_c(qx_reg, ax_reg);
                wy_reg <= sub_c(qy_reg, ay_reg);
            end
            OP_C2A: begin
                c1_reg  <= acc_reg[C1_W-1:0];
                acc_reg <= mac;
            end
            OP_PXA: begin
                c2_reg  <= acc_reg[C1_W-1:0];
                acc_reg <= mac;
            end
            OP_C1A, OP_C1B, OP_C2B, OP_PXB, OP_PYA, OP_PYB,
            OP_NP_DX, OP_NP_DY, OP_CR_MUL: acc_reg <= mac;
            OP_TGT_A: begin
                tx_reg <= ax_reg; ty_reg <= ay_reg;
            end
            OP_TGT_B: begin
                tx_reg <= bx_reg; ty_reg <= by_reg;
            end
            OP_DIV_X:  qneg_reg <= vx_reg[DIFF_W-1];
            OP_DIV_Y:  qneg_reg <= vy_reg[DIFF_W-1];
            OP_CR_DIV: qneg_reg <= acc_reg[ACC_W-1] ^ e3_reg[DIFF_W-1];
            OP_LX:     tx_reg <= lx_sum[COORD_W-1:0];
            OP_LY:     ty_reg <= ly_sum[COORD_W-1:0];
            OP_NP_SET: begin
                dx_reg   <= sub_c(qx_reg, tx_reg);
                dy_reg   <= sub_c(qy_reg, ty_reg);
                sent_reg <= is_sent(qx_reg, qy_reg) || is_sent(tx_reg, ty_reg);
            end
            OP_CR_SET_N: begin
                e1_reg <= sub_c(ax_reg, bx_reg);
                e2_reg <= sub_c(qy_reg, by_reg);
                e3_reg <= sub_c(ay_reg, by_reg);
                ix_reg <= bx_reg;
                ccond_reg <= ((by_reg <= qy_reg) && (qy_reg < ay_reg)) ||
                             ((ay_reg <= qy_reg) && (qy_reg < by_reg));
            end
            OP_CR_SET_C: begin
                e1_reg <= sub_c(bx_reg, ax_reg);
                e2_reg <= sub_c(qy_reg, ay_reg);
                e3_reg <= sub_c(by_reg, ay_reg);
                ix_reg <= ax_reg;
                ccond_reg <= ((by_reg <= qy_reg) && (qy_reg < ay_reg)) ||
                             ((ay_reg <= qy_reg) && (qy_reg < by_reg));
            end
            OP_RESULT: begin
                out_reg.hit        <= in_poly || near_reg;
                out_reg.inside_res <= in_poly;
                out_reg.near_edge  <= near_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.box_ok     = box_ok_reg;
        stat.c1_pos     = c1_reg > 0;
        stat.c2_le_c1   = acc_reg <= c1_ext;
        stat.cross_cond = ccond_reg;
        stat.div_busy   = div_busy;
        stat.kind       = kind_reg;
        stat.last       = last_reg;
    end

    assign out_item = out_reg;

endmodule

@@ design/spht_ctrl.sv @@
// Controller: sequences the datapath through the point, segment and crossing tests.
module spht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  spht_pkg::stat_t   stat,
    output spht_pkg::cmd_t    cmd
);
    import spht_pkg::*;

    localparam logic [STATE_W-1:0] ST_IDLE = 5'd0;
    localparam logic [STATE_W-1:0] ST_DISP = 5'd1;
    localparam logic [STATE_W-1:0] ST_POST = 5'd2;
    localparam logic [STATE_W-1:0] ST_CLS  = 5'd3;
    localparam logic [STATE_W-1:0] ST_BOX  = 5'd4;
    localparam logic [STATE_W-1:0] ST_VW   = 5'd5;
    localparam logic [STATE_W-1:0] ST_C1A  = 5'd6;
    localparam logic [STATE_W-1:0] ST_C1B  = 5'd7;
    localparam logic [STATE_W-1:0] ST_C2A  = 5'd8;
    localparam logic [STATE_W-1:0] ST_C2B  = 5'd9;
    localparam logic [STATE_W-1:0] ST_DEC  = 5'd10;
    localparam logic [STATE_W-1:0] ST_PXB  = 5'd11;
    localparam logic [STATE_W-1:0] ST_DIVX = 5'd12;
    localparam logic [STATE_W-1:0] ST_WX   = 5'd13;
    localparam logic [STATE_W-1:0] ST_PYA  = 5'd14;
    localparam logic [STATE_W-1:0] ST_PYB  = 5'd15;
    localparam logic [STATE_W-1:0] ST_DIVY = 5'd16;
    localparam logic [STATE_W-1:0] ST_WY   = 5'd17;
    localparam logic [STATE_W-1:0] ST_NPS  = 5'd18;
    localparam logic [STATE_W-1:0] ST_NPX  = 5'd19;
    localparam logic [STATE_W-1:0] ST_NPY  = 5'd20;
    localparam logic [STATE_W-1:0] ST_NPC  = 5'd21;
    localparam logic [STATE_W-1:0] ST_CRS  = 5'd22;
    localparam logic [STATE_W-1:0] ST_CRM  = 5'd23;
    localparam logic [STATE_W-1:0] ST_CRD  = 5'd24;
    localparam logic [STATE_W-1:0] ST_CRW  = 5'd25;
    localparam logic [STATE_W-1:0] ST_RES  = 5'd26;

    localparam logic [1:0] CTX_PT    = 2'd0;
    localparam logic [1:0] CTX_SEG   = 2'd1;
    localparam logic [1:0] CTX_CLOSE = 2'd2;

    logic [STATE_W-1:0] state_reg, state_next, line_ret, cross_ret;
    logic [1:0]         ctx_reg, ctx_next;
    logic               in_shape_reg, in_shape_next;
    logic               m_valid_reg, m_valid_next;
    op_t                op;

    always_comb begin
        case (ctx_reg)
            CTX_PT:    line_ret = ST_POST;
            CTX_SEG:   line_ret = stat.kind[1] ? ST_CRS : ST_POST;
            default:   line_ret = ST_RES;
        endcase
        cross_ret = (ctx_reg == CTX_CLOSE) ? ST_BOX : ST_POST;
    end

    always_comb begin
        state_next    = state_reg;
        ctx_next      = ctx_reg;
        in_shape_next = in_shape_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        op            = OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (!in_shape_reg) begin
                    op = OP_FIRST;
                    in_shape_next = 1'b1;
                    if (stat.kind == KIND_POINT) begin
                        ctx_next = CTX_PT;
                        state_next = ST_NPS;
                    end else begin
                        state_next = ST_POST;
                    end
                end else if (stat.kind != KIND_POINT) begin
                    op = OP_SEG_PREV;
                    ctx_next = CTX_SEG;
                    state_next = ST_BOX;
                end else begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                op = OP_PREV;
                if (!stat.last) begin
                    state_next = ST_IDLE;
                end else if (stat.kind[1]) begin
                    state_next = ST_CLS;
                end else begin
                    state_next = ST_RES;
                end
            end
            ST_CLS: begin
                op = OP_SEG_FRST;
                ctx_next = CTX_CLOSE;
                state_next = ST_CRS;
            end
            ST_BOX: begin
                op = OP_BOX;
                state_next = ST_VW;
            end
            ST_VW: begin
                if (!stat.box_ok) begin
                    state_next = line_ret;
                end else begin
                    op = OP_VW;
                    state_next = ST_C1A;
                end
            end
            ST_C1A: begin
                op = OP_C1A;
                state_next = ST_C1B;
            end
            ST_C1B: begin
                op = OP_C1B;
                state_next = ST_C2A;
            end
            ST_C2A: begin
                op = OP_C2A;
                state_next = ST_C2B;
            end
            ST_C2B: begin
                op = OP_C2B;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (!stat.c1_pos) begin
                    op = OP_TGT_A;
                    state_next = ST_NPS;
                end else if (stat.c2_le_c1) begin
                    op = OP_TGT_B;
                    state_next = ST_NPS;
                end else begin
                    op = OP_PXA;
                    state_next = ST_PXB;
                end
            end
            ST_PXB: begin
                op = OP_PXB;
                state_next = ST_DIVX;
            end
            ST_DIVX: begin
                op = OP_DIV_X;
                state_next = ST_WX;
            end
            ST_WX: begin
                if (!stat.div_busy) begin
                    op = OP_LX;
                    state_next = ST_PYA;
                end
            end
            ST_PYA: begin
                op = OP_PYA;
                state_next = ST_PYB;
            end
            ST_PYB: begin
                op = OP_PYB;
                state_next = ST_DIVY;
            end
            ST_DIVY: begin
                op = OP_DIV_Y;
                state_next = ST_WY;
            end
            ST_WY: begin
                if (!stat.div_busy) begin
                    op = OP_LY;
                    state_next = ST_NPS;
                end
            end
            ST_NPS: begin
                op = OP_NP_SET;
                state_next = ST_NPX;
            end
            ST_NPX: begin
                op = OP_NP_DX;
                state_next = ST_NPY;
            end
            ST_NPY: begin
                op = OP_NP_DY;
                state_next = ST_NPC;
            end
            ST_NPC: begin
                op = OP_NP_CMP;
                state_next = line_ret;
            end
            ST_CRS: begin
                op = (ctx_reg == CTX_CLOSE) ? OP_CR_SET_C : OP_CR_SET_N;
                state_next = ST_CRM;
            end
            ST_CRM: begin
                if (!stat.cross_cond) begin
                    state_next = cross_ret;
                end else begin
                    op = OP_CR_MUL;
                    state_next = ST_CRD;
                end
            end
            ST_CRD: begin
                op = OP_CR_DIV;
                state_next = ST_CRW;
            end
            ST_CRW: begin
                if (!stat.div_busy) begin
                    op = OP_CR_CMP;
                    state_next = cross_ret;
                end
            end
            ST_RES: begin
                if (!m_valid_reg || m_ready) begin
                    op = OP_RESULT;
                    m_valid_next = 1'b1;
                    in_shape_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ctx_reg      <= CTX_PT;
            in_shape_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ctx_reg      <= ctx_next;
            in_shape_reg <= in_shape_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign cmd.op  = op;

endmodule

@@ design/shape_proximity_hit_test.sv @@
// Top level of the shape proximity hit test: controller, datapath and assertions.
// Vertices of one shape arrive one item at a time; the item that carries last_vertex
// produces a single result with hit, inside_res and near_edge for the configured query
// point and radius. One vertex is processed at a time. A vertex runs no test, the point
// test, or a segment test that its bounding box may reject before the projected point
// is needed; in a polygon each edge adds a crossing check, with a division when the
// crossing needs it. The closing vertex of a polygon adds the closing crossing and
// segment tests. A result is written once the receiver has taken the previous one.
// The speed is set by the 17-step serial divider, which a segment uses twice and a
// crossing test once, and by the single shared 17x18 multiplier. A finished result
// waits in an output register while the next vertex is accepted.
module shape_proximity_hit_test (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  spht_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output spht_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spht_pkg::COORD_W-1:0]    cfg_data
);
    import spht_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    spht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spht_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (m_data)
    );

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DIV_X || cmd.op == OP_DIV_Y || cmd.op == OP_CR_DIV) |-> !stat.div_busy)
        else $error("Divider started while still busy.");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second item was taken while one is in work.");

    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_RESULT) |-> (!m_valid || m_ready))
        else $error("Result written over an undelivered item.");

    a_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> stat.last)
        else $error("Result raised for an item that is not the last vertex.");

endmodule

@@ tb/sv/spht_checker.sv @@
// Checker of the shape proximity hit test: predicts each result and compares it on the m_ side.
module spht_checker
    import spht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_W-1:0]    cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    longint qx, qy, radius;
    longint fx, fy, px, py;
    bit     open_shape, parity, near_hit;
    out_item_t hit_queue[$];

    function automatic bit on_sentinel(longint x, longint y);
        return x == 32767 || y == 32767 || x == -32768 || y == -32768;
    endfunction

    function automatic bit close_to(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        if (on_sentinel(ax, ay) || on_sentinel(bx, by)) return 0;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy <= radius * radius;
    endfunction

    function automatic bit close_to_segment(longint ax, longint ay, longint bx, longint by);
        longint vx, vy, wx, wy, c1, c2, lx, ly;
        if (ax < bx) begin
            if (qx < ax - radius || qx > bx + radius) return 0;
        end else begin
            if (qx < bx - radius || qx > ax + radius) return 0;
        end
        if (ay < by) begin
            if (qy < ay - radius || qy > by + radius) return 0;
        end else begin
            if (qy < by - radius || qy > ay + radius) return 0;
        end
        vx = bx - ax;
        vy = by - ay;
        wx = qx - ax;
        wy = qy - ay;
        c1 = vx * wx + vy * wy;
        if (c1 <= 0) return close_to(qx, qy, ax, ay);
        c2 = vx * vx + vy * vy;
        if (c2 <= c1) return close_to(qx, qy, bx, by);
        lx = ax + vx * c1 / c2;
        ly = ay + vy * c1 / c2;
        return close_to(qx, qy, lx, ly);
    endfunction

    function automatic bit edge_crosses(longint ix, longint iy, longint jx, longint jy);
        if (!((iy <= qy && qy < jy) || (jy <= qy && qy < iy))) return 0;
        return qx < (jx - ix) * (qy - iy) / (jy - iy) + ix;
    endfunction

    task automatic vertex_step(input in_item_t it);
        longint    x, y;
        bit        poly, in_poly;
        out_item_t r;
        x = longint'(it.vert_x);
        y = longint'(it.vert_y);
        poly = it.shape_kind >= 2;
        if (!open_shape) begin
            fx = x;
            fy = y;
            parity = 0;
            near_hit = (it.shape_kind == KIND_POINT) ? close_to(qx, qy, x, y) : 0;
            open_shape = 1;
        end else if (it.shape_kind != KIND_POINT) begin
            if (close_to_segment(px, py, x, y)) near_hit = 1;
            if (poly && edge_crosses(x, y, px, py)) parity = !parity;
        end
        px = x;
        py = y;
        if (it.last_vertex) begin
            if (poly) begin
                if (edge_crosses(fx, fy, x, y)) parity = !parity;
                if (close_to_segment(fx, fy, x, y)) near_hit = 1;
            end
            in_poly = poly && parity;
            r.hit = in_poly || near_hit;
            r.inside_res = in_poly;
            r.near_edge = near_hit;
            hit_queue.push_back(r);
            open_shape = 0;
            parity = 0;
            near_hit = 0;
        end
    endtask

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        qx = 0; qy = 0; radius = 0;
        fx = 0; fy = 0; px = 0; py = 0;
        open_shape = 0; parity = 0; near_hit = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_QUERY_X: qx = longint'($signed(cfg_data));
                    CFG_QUERY_Y: qy = longint'($signed(cfg_data));
                    CFG_RADIUS:  radius = longint'(cfg_data[RAD_W-1:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) vertex_step(s_data);
            if (m_valid && m_ready) begin
                if (hit_queue.size() == 0) begin
                    report("result item with none expected");
                end else begin
                    if (m_data.hit !== hit_queue[0].hit)
                        report($sformatf("hit %b, expected %b", m_data.hit, hit_queue[0].hit));
                    if (m_data.inside_res !== hit_queue[0].inside_res)
                        report($sformatf("inside_res %b, expected %b",
                                         m_data.inside_res, hit_queue[0].inside_res));
                    if (m_data.near_edge !== hit_queue[0].near_edge)
                        report($sformatf("near_edge %b, expected %b",
                                         m_data.near_edge, hit_queue[0].near_edge));
                    void'(hit_queue.pop_front());
                end
            end
            pending = hit_queue.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top of the shape proximity hit test: clock, reset, stimulus and verdict.
module tb_top;
    import spht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_valid = 0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 0;
    out_item_t            m_data;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_QUERY_X;
    logic [COORD_W-1:0]   cfg_data = '0;
    int                   fail_count, pending;

    int burst_left = 0;
    int sent = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    logic signed [15:0] cur_qx = 0, cur_qy = 0;
    int cur_rad = 0;

    always #1 aclk = ~aclk;

    shape_proximity_hit_test dut (.*);

    spht_checker checker_i (.*);

    initial begin
        #2000000;
        $display("shape_proximity_hit_test regression: fail");
        $finish;
    end

    initial begin
        int mode, left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 0;
                repeat (500) @(negedge aclk);
                hold_done = 1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0: m_ready <= 1;
                    1: m_ready <= $urandom_range(0, 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_vertex(input int x, input int y, input int kind, input bit last);
        s_data.vert_x <= 16'(x);
        s_data.vert_y <= 16'(y);
        s_data.shape_kind <= 2'(kind);
        s_data.last_vertex <= last;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic drain;
        s_valid <= 0;
        do @(posedge aclk); while (pending != 0);
        repeat (200) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data <= 16'(value);
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic configure(input int x, input int y, input int rad);
        drain();
        write_reg(CFG_QUERY_X, x);
        write_reg(CFG_QUERY_Y, y);
        write_reg(CFG_RADIUS, rad);
        cur_qx = 16'(x);
        cur_qy = 16'(y);
        cur_rad = rad & 16'h7fff;
    endtask

    task automatic random_shape;
        int kind, n, span, x, y, vk;
        bit wide;
        kind = $urandom_range(0, 3);
        n = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        wide = ($urandom_range(0, 4) == 0);
        span = (cur_rad > 2000 ? 2000 : cur_rad) * 3 + 8;
        for (int i = 0; i < n; i++) begin
            if (wide) begin
                x = $urandom_range(0, 65535);
                y = $urandom_range(0, 65535);
            end else begin
                x = int'(cur_qx) + $urandom_range(0, 2 * span) - span;
                y = int'(cur_qy) + $urandom_range(0, 2 * span) - span;
            end
            if ($urandom_range(0, 20) == 0) x = $urandom_range(0, 1) ? 32767 : -32768;
            if ($urandom_range(0, 20) == 0) y = $urandom_range(0, 1) ? 32767 : -32768;
            vk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : kind;
            send_vertex(x, y, vk, i == n - 1);
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        send_vertex(0, 0, 0, 1);
        send_vertex(1, 0, 0, 1);
        configure(100, 100, 10);
        send_vertex(32767, 100, 0, 1);
        send_vertex(105, 100, 0, 1);
        send_vertex(100, 100, 1, 1);
        send_vertex(0, 100, 1, 0);
        send_vertex(200, 100, 1, 1);
        send_vertex(0, 0, 1, 0);
        send_vertex(10, 0, 1, 1);
        send_vertex(0, 0, 2, 0);
        send_vertex(200, 0, 2, 0);
        send_vertex(200, 200, 2, 0);
        send_vertex(0, 200, 2, 1);
        send_vertex(50, 50, 3, 0);
        send_vertex(300, 80, 3, 0);
        send_vertex(60, 400, 3, 1);
        send_vertex(100, 100, 2, 1);
        send_vertex(100, 100, 0, 0);
        send_vertex(300, 300, 1, 1);
        configure(-32768, 32767, 32767);
        send_vertex(-32768, -32768, 1, 0);
        send_vertex(32767, 32767, 1, 1);
        send_vertex(-32767, 32766, 0, 1);
        configure(32767, -32768, 0);
        send_vertex(-32768, 32767, 2, 0);
        send_vertex(32767, 32767, 2, 0);
        send_vertex(0, -32768, 2, 1);
        configure(-5, 7, 32767);
        send_vertex(-32767, -32767, 2, 0);
        send_vertex(32766, -32767, 2, 0);
        send_vertex(0, 32766, 2, 1);

        while (sent < 550) begin
            if (sent > 150 && !hold_req) hold_req = 1;
            if ($urandom_range(0, 60) == 0) begin
                case ($urandom_range(0, 3))
                    0: configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535));
                    1: configure($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                                 $urandom_range(0, 0));
                    2: configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(32000, 32767));
                    default: configure($urandom_range(0, 2000) - 1000,
                                       $urandom_range(0, 2000) - 1000, $urandom_range(1, 300));
                endcase
            end
            random_shape();
        end
        drain();

        if (fail_count == 0) begin
            $display("shape_proximity_hit_test regression: pass");
        end else begin
            $display("shape_proximity_hit_test regression: fail");
        end
        $finish;
    end

endmodule
